/* hw/rtl/stcd_pkg.sv */
`timescale 1ns / 1ps
// Package for the stick-to-cursor block: sequencer states, register indexes,
// reset values and fixed constants. No dependencies.
package stcd_pkg;

  localparam int MUL_W = 32;
  localparam int DIV_DW = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int FIX_W = 16;
  localparam int GAIN_W = 6;
  localparam int K_W = 12;
  localparam int STICK_W = 16;
  localparam int DELTA_W = 12;

  localparam logic [14:0] FULL_SCALE = 15'd32767;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SENS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL = 3'd5;

  localparam logic [FIX_W-1:0] RADIAL_RST = 16'd6554;
  localparam logic [FIX_W-1:0] AXIAL_RST = 16'd0;
  localparam logic [FIX_W-1:0] OUTER_RST = 16'd1966;
  localparam logic [FIX_W-1:0] SLOPE_RST = 16'd10486;
  localparam logic [GAIN_W-1:0] SENS_RST = 6'd12;
  localparam logic [GAIN_W-1:0] ACCEL_RST = 6'd4;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_THR,
    ST_THR_SQ,
    ST_AXX,
    ST_AYY,
    ST_AXT,
    ST_CHK,
    ST_SQ_WAIT,
    ST_M_START,
    ST_M_WAIT,
    ST_R_START,
    ST_R_WAIT,
    ST_P_INIT,
    ST_P_MUL,
    ST_P_ACC,
    ST_CV_1,
    ST_CV_2,
    ST_CV_3,
    ST_K,
    ST_D_START,
    ST_D_WAIT,
    ST_S_1,
    ST_S_2,
    ST_S_3,
    ST_ACC,
    ST_ZERO,
    ST_OUT
  } state_t;

endpackage

/* hw/rtl/stcd_mul.sv */
`timescale 1ns / 1ps
// Shared 32 x 32 unsigned multiplier with a registered product.
// Depends on stcd_pkg for the operand width.
module stcd_mul (
  input  logic                           clk,
  input  logic [stcd_pkg::MUL_W-1:0]     a,
  input  logic [stcd_pkg::MUL_W-1:0]     b,
  output logic [2*stcd_pkg::MUL_W-1:0]   p_r
);

  logic [2*stcd_pkg::MUL_W-1:0] p_nxt;

  assign p_nxt = (2*stcd_pkg::MUL_W)'(a) * (2*stcd_pkg::MUL_W)'(b);

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

/* hw/rtl/stcd_sqrt.sv */
`timescale 1ns / 1ps
// Digit-by-digit integer square root of r2 * 2^32, two radicand bits a cycle.
// Has no dependencies; its widths are fixed.
module stcd_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] r2,
  output logic        busy,
  output logic [31:0] root
);

  logic [63:0] rad_r, rad_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [33:0] sh;
  logic [33:0] trial;
  logic        ge;

  assign sh = {rem_r[31:0], rad_r[63:62]};
  assign trial = {root_r, 2'b01};
  assign ge = sh >= trial;

  always_comb begin
    rad_nxt = rad_r;
    rem_nxt = rem_r;
    root_nxt = root_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rad_nxt = {r2, 32'd0};
      rem_nxt = '0;
      root_nxt = '0;
      cnt_nxt = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[61:0], 2'b00};
      rem_nxt = ge ? (sh - trial) : sh;
      root_nxt = {root_r[30:0], ge};
      cnt_nxt = cnt_r - 6'd1;
      busy_nxt = (cnt_r != 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r <= rad_nxt;
    rem_r <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

/* hw/rtl/stcd_div.sv */
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle.
// Depends on stcd_pkg for the divisor width.
module stcd_div #(
  parameter int NW = 48
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [NW-1:0]               num,
  input  logic [stcd_pkg::DIV_DW-1:0] den,
  output logic                        busy,
  output logic [NW-1:0]               quot
);

  localparam int DW = stcd_pkg::DIV_DW;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [DW:0]   sh;
  logic          ge;

  assign sh = {rem_r, q_r[NW-1]};
  assign ge = sh >= {1'b0, den_r};

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt = {q_r[NW-2:0], ge};
      rem_nxt = ge ? DW'(sh - {1'b0, den_r}) : DW'(sh);
      cnt_nxt = cnt_r - CW'(1);
      busy_nxt = (cnt_r != CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy = busy_r;
  assign quot = q_r;

endmodule

/* hw/rtl/stick_to_cursor_delta.sv */
`timescale 1ns / 1ps
// Stick-to-cursor step: radial and axial deadzones, response curve and fraction
// accumulators. Uses stcd_pkg, stcd_mul, stcd_sqrt and stcd_div.
// A moving sample takes three divider passes and the 32-step square root; one
// pass less at the deadzone edge, and neither in a deadzone. One transaction at a
// time, the next is taken after the result leaves. Reset restores all defaults.
module stick_to_cursor_delta #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [stcd_pkg::STICK_W-1:0]   in_stick_x,
  input  logic signed [stcd_pkg::STICK_W-1:0]   in_stick_y,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [stcd_pkg::DELTA_W-1:0]   out_delta_x,
  output logic signed [stcd_pkg::DELTA_W-1:0]   out_delta_y,
  input  logic                                  cfg_we,
  input  logic [stcd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [stcd_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int F = FRAC_BITS;
  localparam int NW = F + 32;
  localparam int TW = F + 16;
  localparam int MW = stcd_pkg::MUL_W;
  localparam int SW = F + 11;
  localparam int SUMW = F + 13;
  localparam int DW = stcd_pkg::DELTA_W;
  localparam logic [F:0] ONE = (F+1)'(1) << F;
  localparam int SPAN_EPS = ((1 << F) + 999999) / 1000000;

  stcd_pkg::state_t state_r, state_nxt;

  logic [stcd_pkg::FIX_W-1:0]  radial_r, axial_r, outer_r, slope_r;
  logic [stcd_pkg::GAIN_W-1:0] sens_r, accel_r;

  logic [15:0]          ax_r, ay_r;
  logic                 neg_r [2];
  logic [61:0]          thr_r;
  logic [31:0]          axx_r, ayy_r;
  logic [31:0]          root_r;
  logic [TW-1:0]        fold_r;
  logic [F:0]           m_r;
  logic [F:0]           r_r;
  logic [F:0]           pw_r;
  logic [1:0]           pcnt_r;
  logic [2*MW-1:0]      sr_r;
  logic [F:0]           curve_r;
  logic [stcd_pkg::K_W-1:0] k_r;
  logic [F:0]           dir_r;
  logic                 axis_r;
  logic [SW-1:0]        step_r [2];
  logic signed [F:0]    acc_r [2];
  logic signed [DW-1:0] dx_r, dy_r;

  logic [MW-1:0]        mul_a, mul_b;
  logic [2*MW-1:0]      mul_p;
  logic                 sq_start, sq_busy;
  logic [31:0]          sq_root;
  logic                 div_start, div_busy;
  logic [NW-1:0]        div_num, div_quot;
  logic [31:0]          div_den;

  logic [15:0]          in_ax, in_ay;
  logic                 radial_in;
  logic                 zx, zy;
  logic [31:0]          r2_eff;
  logic [F+15:0]        dz_ext, outer_ext, slope_ext;
  logic [F-1:0]         dz_q, outer_q, slope_q;
  logic signed [F+1:0]  span_s;
  logic [F:0]           span;
  logic [15:0]          dir_src;
  logic [F+31:0]        root_ext;
  logic                 fold_more;

  logic signed [SUMW-1:0] sum_c [2];
  logic [SUMW-1:0]        mag_c [2];
  logic [DW-1:0]          whole_c [2];
  logic [F-1:0]           rem_c [2];
  logic signed [F:0]      acc_c [2];

  stcd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  stcd_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .r2    (r2_eff),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  stcd_div #(.NW(NW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  assign in_ax = 16'(~in_stick_x + 16'sd1);
  assign in_ay = 16'(~in_stick_y + 16'sd1);

  assign dz_ext = {radial_r, {F{1'b0}}};
  assign outer_ext = {outer_r, {F{1'b0}}};
  assign slope_ext = {slope_r, {F{1'b0}}};
  assign dz_q = dz_ext[F+15:16];
  assign outer_q = outer_ext[F+15:16];
  assign slope_q = slope_ext[F+15:16];
  assign span_s = $signed((F+2)'(ONE)) - $signed((F+2)'(outer_q)) - $signed((F+2)'(dz_q));
  assign span = (span_s < $signed((F+2)'(SPAN_EPS))) ? ONE : (F+1)'(span_s);

  assign radial_in = {(axx_r + ayy_r), 32'd0} < {2'b00, thr_r};
  assign zx = {ax_r, 16'd0} < mul_p[31:0];
  assign zy = {ay_r, 16'd0} < mul_p[31:0];
  assign r2_eff = (zx ? 32'd0 : axx_r) + (zy ? 32'd0 : ayy_r);
  assign dir_src = axis_r ? ay_r : ax_r;

  // The magnitude divides by 2^15 - 1 by folding the high part onto the low part.
  assign root_ext = {root_r, {F{1'b0}}};
  assign fold_more = fold_r >= TW'(stcd_pkg::FULL_SCALE);

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      sum_c[i] = neg_r[i] ? (SUMW'(acc_r[i]) - $signed(SUMW'(step_r[i])))
                          : (SUMW'(acc_r[i]) + $signed(SUMW'(step_r[i])));
      mag_c[i] = sum_c[i][SUMW-1] ? SUMW'(-sum_c[i]) : SUMW'(sum_c[i]);
      whole_c[i] = mag_c[i][F+11:F];
      rem_c[i] = mag_c[i][F-1:0];
      acc_c[i] = sum_c[i][SUMW-1] ? ((F+1)'(0) - (F+1)'(rem_c[i])) : (F+1)'(rem_c[i]);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      stcd_pkg::ST_IDLE:    if (in_valid) state_nxt = stcd_pkg::ST_THR;
      stcd_pkg::ST_THR:     state_nxt = stcd_pkg::ST_THR_SQ;
      stcd_pkg::ST_THR_SQ:  state_nxt = stcd_pkg::ST_AXX;
      stcd_pkg::ST_AXX:     state_nxt = stcd_pkg::ST_AYY;
      stcd_pkg::ST_AYY:     state_nxt = stcd_pkg::ST_AXT;
      stcd_pkg::ST_AXT:     state_nxt = stcd_pkg::ST_CHK;
      stcd_pkg::ST_CHK: begin
        if (radial_in || (r2_eff == 32'd0)) state_nxt = stcd_pkg::ST_ZERO;
        else state_nxt = stcd_pkg::ST_SQ_WAIT;
      end
      stcd_pkg::ST_SQ_WAIT: if (!sq_busy) state_nxt = stcd_pkg::ST_M_START;
      stcd_pkg::ST_M_START: state_nxt = stcd_pkg::ST_M_WAIT;
      stcd_pkg::ST_M_WAIT:  if (!fold_more) state_nxt = stcd_pkg::ST_R_START;
      stcd_pkg::ST_R_START: begin
        if (m_r <= (F+1)'(dz_q)) state_nxt = stcd_pkg::ST_P_INIT;
        else state_nxt = stcd_pkg::ST_R_WAIT;
      end
      stcd_pkg::ST_R_WAIT:  if (!div_busy) state_nxt = stcd_pkg::ST_P_INIT;
      stcd_pkg::ST_P_INIT:  state_nxt = stcd_pkg::ST_P_MUL;
      stcd_pkg::ST_P_MUL:   state_nxt = stcd_pkg::ST_P_ACC;
      stcd_pkg::ST_P_ACC: begin
        if (pcnt_r == 2'd3) state_nxt = stcd_pkg::ST_CV_1;
        else state_nxt = stcd_pkg::ST_P_MUL;
      end
      stcd_pkg::ST_CV_1:    state_nxt = stcd_pkg::ST_CV_2;
      stcd_pkg::ST_CV_2:    state_nxt = stcd_pkg::ST_CV_3;
      stcd_pkg::ST_CV_3:    state_nxt = stcd_pkg::ST_K;
      stcd_pkg::ST_K:       state_nxt = stcd_pkg::ST_D_START;
      stcd_pkg::ST_D_START: state_nxt = stcd_pkg::ST_D_WAIT;
      stcd_pkg::ST_D_WAIT:  if (!div_busy) state_nxt = stcd_pkg::ST_S_1;
      stcd_pkg::ST_S_1:     state_nxt = stcd_pkg::ST_S_2;
      stcd_pkg::ST_S_2:     state_nxt = stcd_pkg::ST_S_3;
      stcd_pkg::ST_S_3: begin
        if (axis_r) state_nxt = stcd_pkg::ST_ACC;
        else state_nxt = stcd_pkg::ST_D_START;
      end
      stcd_pkg::ST_ACC:     state_nxt = stcd_pkg::ST_OUT;
      stcd_pkg::ST_ZERO:    state_nxt = stcd_pkg::ST_OUT;
      stcd_pkg::ST_OUT:     if (!out_stall) state_nxt = stcd_pkg::ST_IDLE;
      default:              state_nxt = stcd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    sq_start = 1'b0;
    div_start = 1'b0;
    div_num = '0;
    div_den = '0;
    unique case (state_r)
      stcd_pkg::ST_THR: begin
        mul_a = MW'(radial_r);
        mul_b = MW'(stcd_pkg::FULL_SCALE);
      end
      stcd_pkg::ST_THR_SQ: begin
        mul_a = mul_p[MW-1:0];
        mul_b = mul_p[MW-1:0];
      end
      stcd_pkg::ST_AXX: begin
        mul_a = MW'(ax_r);
        mul_b = MW'(ax_r);
      end
      stcd_pkg::ST_AYY: begin
        mul_a = MW'(ay_r);
        mul_b = MW'(ay_r);
      end
      stcd_pkg::ST_AXT: begin
        mul_a = MW'(axial_r);
        mul_b = MW'(stcd_pkg::FULL_SCALE);
      end
      stcd_pkg::ST_CHK: sq_start = !(radial_in || (r2_eff == 32'd0));
      stcd_pkg::ST_R_START: begin
        div_start = !(m_r <= (F+1)'(dz_q));
        div_num = NW'(m_r - (F+1)'(dz_q)) << F;
        div_den = 32'(span);
      end
      stcd_pkg::ST_P_MUL: begin
        mul_a = MW'(pw_r);
        mul_b = MW'(r_r);
      end
      stcd_pkg::ST_CV_1: begin
        mul_a = MW'(slope_q);
        mul_b = MW'(r_r);
      end
      stcd_pkg::ST_CV_2: begin
        mul_a = MW'(ONE - (F+1)'(slope_q));
        mul_b = MW'(pw_r);
      end
      stcd_pkg::ST_CV_3: begin
        mul_a = MW'(sens_r);
        mul_b = MW'(accel_r);
      end
      stcd_pkg::ST_D_START: begin
        div_start = 1'b1;
        div_num = NW'(dir_src) << (F + 16);
        div_den = root_r;
      end
      stcd_pkg::ST_S_1: begin
        mul_a = MW'(curve_r);
        mul_b = MW'(dir_r);
      end
      stcd_pkg::ST_S_2: begin
        mul_a = MW'(mul_p[2*F:F]);
        mul_b = MW'(k_r);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign in_stall = (state_r != stcd_pkg::ST_IDLE);
  assign out_valid = (state_r == stcd_pkg::ST_OUT);
  assign out_delta_x = dx_r;
  assign out_delta_y = dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stcd_pkg::ST_IDLE;
      radial_r <= stcd_pkg::RADIAL_RST;
      axial_r <= stcd_pkg::AXIAL_RST;
      outer_r <= stcd_pkg::OUTER_RST;
      slope_r <= stcd_pkg::SLOPE_RST;
      sens_r <= stcd_pkg::SENS_RST;
      accel_r <= stcd_pkg::ACCEL_RST;
      acc_r[0] <= '0;
      acc_r[1] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          stcd_pkg::CFG_RADIAL: radial_r <= cfg_data;
          stcd_pkg::CFG_AXIAL:  axial_r <= cfg_data;
          stcd_pkg::CFG_OUTER:  outer_r <= cfg_data;
          stcd_pkg::CFG_SLOPE:  slope_r <= cfg_data;
          stcd_pkg::CFG_SENS:   sens_r <= cfg_data[stcd_pkg::GAIN_W-1:0];
          stcd_pkg::CFG_ACCEL:  accel_r <= cfg_data[stcd_pkg::GAIN_W-1:0];
          default:              sens_r <= sens_r;
        endcase
      end
      if (state_r == stcd_pkg::ST_ACC) begin
        acc_r[0] <= acc_c[0];
        acc_r[1] <= acc_c[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      stcd_pkg::ST_IDLE: begin
        ax_r <= in_stick_x[15] ? in_ax : 16'(in_stick_x);
        ay_r <= in_stick_y[15] ? in_ay : 16'(in_stick_y);
        neg_r[0] <= in_stick_x[15];
        neg_r[1] <= in_stick_y[15];
        axis_r <= 1'b0;
      end
      stcd_pkg::ST_AXX: thr_r <= mul_p[61:0];
      stcd_pkg::ST_AYY: axx_r <= mul_p[31:0];
      stcd_pkg::ST_AXT: ayy_r <= mul_p[31:0];
      stcd_pkg::ST_CHK: begin
        if (zx) ax_r <= '0;
        if (zy) ay_r <= '0;
      end
      stcd_pkg::ST_SQ_WAIT: root_r <= sq_root;
      stcd_pkg::ST_M_START: begin
        fold_r <= root_ext[F+31:16];
        m_r <= '0;
      end
      stcd_pkg::ST_M_WAIT: begin
        if (fold_r == TW'(stcd_pkg::FULL_SCALE)) begin
          fold_r <= '0;
          m_r <= m_r + (F+1)'(1);
        end else if (fold_more) begin
          fold_r <= TW'(fold_r[TW-1:15]) + TW'(fold_r[14:0]);
          m_r <= m_r + fold_r[TW-1:15];
        end
      end
      stcd_pkg::ST_R_START: r_r <= '0;
      stcd_pkg::ST_R_WAIT: r_r <= (div_quot > NW'(ONE)) ? ONE : div_quot[F:0];
      stcd_pkg::ST_P_INIT: begin
        pw_r <= r_r;
        pcnt_r <= '0;
      end
      stcd_pkg::ST_P_ACC: begin
        pw_r <= mul_p[2*F:F];
        pcnt_r <= pcnt_r + 2'd1;
      end
      stcd_pkg::ST_CV_2: sr_r <= mul_p;
      stcd_pkg::ST_CV_3: curve_r <= (F+1)'((sr_r + mul_p) >> F);
      stcd_pkg::ST_K: k_r <= mul_p[stcd_pkg::K_W-1:0];
      stcd_pkg::ST_D_WAIT: dir_r <= div_quot[F:0];
      stcd_pkg::ST_S_3: begin
        step_r[axis_r] <= mul_p[F+11:1];
        axis_r <= 1'b1;
      end
      stcd_pkg::ST_ACC: begin
        dx_r <= sum_c[0][SUMW-1] ? (DW'(0) - whole_c[0]) : whole_c[0];
        dy_r <= sum_c[1][SUMW-1] ? whole_c[1] : (DW'(0) - whole_c[1]);
      end
      stcd_pkg::ST_ZERO: begin
        dx_r <= '0;
        dy_r <= '0;
      end
      default: begin
        sr_r <= sr_r;
      end
    endcase
  end

endmodule

/* test/tb_stick_to_cursor_delta.sv */
`timescale 1ns / 1ps
// Self-checking testbench for stick_to_cursor_delta: directed and random stick
// samples under several register settings and handshake pressures, checked
// against a fixed-point scoreboard. Depends on stcd_pkg and the block itself.
module tb_stick_to_cursor_delta;

  localparam int CFG_W = stcd_pkg::CFG_DATA_W;
  localparam int STK_W = stcd_pkg::STICK_W;

  class step_scoreboard;
    longint unsigned radial, axial, outer, slope, sens, accel;
    longint acc_x, acc_y;
    logic [stcd_pkg::DELTA_W-1:0] want_x[$];
    logic [stcd_pkg::DELTA_W-1:0] want_y[$];
    int errors;

    function new();
      radial = 64'(stcd_pkg::RADIAL_RST);
      axial = 64'(stcd_pkg::AXIAL_RST);
      outer = 64'(stcd_pkg::OUTER_RST);
      slope = 64'(stcd_pkg::SLOPE_RST);
      sens = 64'(stcd_pkg::SENS_RST);
      accel = 64'(stcd_pkg::ACCEL_RST);
      acc_x = 0;
      acc_y = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [stcd_pkg::CFG_IDX_W-1:0] idx,
                          logic [stcd_pkg::CFG_DATA_W-1:0] v);
      case (idx)
        stcd_pkg::CFG_RADIAL: radial = 64'(v);
        stcd_pkg::CFG_AXIAL: axial = 64'(v);
        stcd_pkg::CFG_OUTER: outer = 64'(v);
        stcd_pkg::CFG_SLOPE: slope = 64'(v);
        stcd_pkg::CFG_SENS: sens = 64'(v[stcd_pkg::GAIN_W-1:0]);
        stcd_pkg::CFG_ACCEL: accel = 64'(v[stcd_pkg::GAIN_W-1:0]);
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function longint take_whole(inout longint acc, input longint unsigned step,
                                input bit neg);
      longint sum, whole, rem;
      longint unsigned mag;
      sum = neg ? acc - longint'(step) : acc + longint'(step);
      mag = (sum < 0) ? longint'(-sum) : sum;
      whole = mag >> 16;
      rem = mag & 64'hFFFF;
      acc = (sum < 0) ? -rem : rem;
      return (sum < 0) ? -whole : whole;
    endfunction

    function void note_sample(logic signed [stcd_pkg::STICK_W-1:0] x,
                              logic signed [stcd_pkg::STICK_W-1:0] y);
      longint unsigned ax, ay, r2, root, m, r, p, curve, k, dir, sx, sy;
      longint span, ix, iy;
      bit nx, ny;
      nx = x < 0;
      ny = y < 0;
      ax = nx ? -longint'(x) : longint'(x);
      ay = ny ? -longint'(y) : longint'(y);
      r2 = ax * ax + ay * ay;
      if ((r2 << 32) < radial * radial * 64'd32767 * 64'd32767) begin
        want_x.push_back('0);
        want_y.push_back('0);
        return;
      end
      if ((ax << 16) < axial * 64'd32767) ax = 0;
      if ((ay << 16) < axial * 64'd32767) ay = 0;
      if (ax == 0 && ay == 0) begin
        want_x.push_back('0);
        want_y.push_back('0);
        return;
      end
      r2 = ax * ax + ay * ay;
      root = int_sqrt(r2 << 32);
      m = (root << 16) / (64'd32767 << 16);
      span = 65536 - longint'(outer) - longint'(radial);
      if (span < 1) span = 65536;
      if (m <= radial) begin
        r = 0;
      end else begin
        r = ((m - radial) << 16) / longint'(span);
        if (r > 65536) r = 65536;
      end
      p = r;
      repeat (4) p = (p * r) >> 16;
      curve = (slope * r + (65536 - slope) * p) >> 16;
      k = sens * accel;
      dir = (ax << 32) / root;
      sx = (((curve * dir) >> 16) * k) >> 1;
      dir = (ay << 32) / root;
      sy = (((curve * dir) >> 16) * k) >> 1;
      ix = take_whole(acc_x, sx, nx);
      iy = take_whole(acc_y, sy, ny);
      iy = -iy;
      want_x.push_back(ix[stcd_pkg::DELTA_W-1:0]);
      want_y.push_back(iy[stcd_pkg::DELTA_W-1:0]);
    endfunction

    function void check_step(logic [stcd_pkg::DELTA_W-1:0] dx,
                             logic [stcd_pkg::DELTA_W-1:0] dy);
      logic [stcd_pkg::DELTA_W-1:0] ex, ey;
      if (want_x.size() == 0) begin
        $display("%0t: unexpected result dx=%0d dy=%0d", $time, $signed(dx), $signed(dy));
        errors++;
        return;
      end
      ex = want_x.pop_front();
      ey = want_y.pop_front();
      if (dx !== ex) begin
        $display("%0t: delta_x expected %0d actual %0d", $time, $signed(ex), $signed(dx));
        errors++;
      end
      if (dy !== ey) begin
        $display("%0t: delta_y expected %0d actual %0d", $time, $signed(ey), $signed(dy));
        errors++;
      end
    endfunction

    function bit drained();
      return want_x.size() == 0;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [stcd_pkg::STICK_W-1:0] in_stick_x;
  logic signed [stcd_pkg::STICK_W-1:0] in_stick_y;
  logic out_valid;
  logic out_stall;
  logic signed [stcd_pkg::DELTA_W-1:0] out_delta_x;
  logic signed [stcd_pkg::DELTA_W-1:0] out_delta_y;
  logic cfg_we;
  logic [stcd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [stcd_pkg::CFG_DATA_W-1:0] cfg_data;

  step_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;

  stick_to_cursor_delta dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_stick_x(in_stick_x), .in_stick_y(in_stick_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_delta_x(out_delta_x), .out_delta_y(out_delta_y),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_step(out_delta_x, out_delta_y);
  end

  // Entered at a falling edge; the sender stays idle while results drain.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (!sb.drained()) @(posedge clk);
  endtask

  task automatic cfg_write(logic [stcd_pkg::CFG_IDX_W-1:0] idx,
                           logic [stcd_pkg::CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(int rd, int ad, int ot, int sl, int se, int ac);
    wait_drain();
    repeat (5) @(posedge clk);
    cfg_write(stcd_pkg::CFG_RADIAL, CFG_W'(rd));
    cfg_write(stcd_pkg::CFG_AXIAL, CFG_W'(ad));
    cfg_write(stcd_pkg::CFG_OUTER, CFG_W'(ot));
    cfg_write(stcd_pkg::CFG_SLOPE, CFG_W'(sl));
    cfg_write(stcd_pkg::CFG_SENS, CFG_W'(se));
    cfg_write(stcd_pkg::CFG_ACCEL, CFG_W'(ac));
  endtask

  // Entered and left at a falling edge.
  task automatic send_sample(logic signed [stcd_pkg::STICK_W-1:0] x,
                             logic signed [stcd_pkg::STICK_W-1:0] y);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_stick_x <= x;
    in_stick_y <= y;
    do @(posedge clk); while (in_stall);
    sb.note_sample(x, y);
    @(negedge clk);
  endtask

  function automatic logic [stcd_pkg::STICK_W-1:0] pick_axis();
    int mag;
    case ($urandom_range(0, 4))
      0, 1: return STK_W'($urandom());
      2: mag = $urandom_range(0, 8000);
      3: mag = $urandom_range(30000, 32767);
      default: return 0;
    endcase
    return STK_W'($urandom_range(0, 1) ? -mag : mag);
  endfunction

  task automatic run_random(int count);
    repeat (count) send_sample(pick_axis(), pick_axis());
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_stick_x = '0;
    in_stick_y = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_sample(0, 0);
    send_sample(32767, 32767);
    send_sample(-32768, -32768);
    send_sample(32767, 0);
    send_sample(0, -32768);
    send_sample(-32768, 32767);
    send_sample(3276, 0);
    send_sample(3277, 0);
    send_sample(3300, -100);
    send_sample(1, -1);
    send_sample(20000, -15000);
    send_sample(-123, 31000);
    apply_setting(6554, 3277, 1966, 10486, 12, 4);
    send_sample(3000, 30000);
    send_sample(-30000, 3276);
    send_sample(3276, -3276);
    send_sample(3277, 3277);
    send_sample(-32768, -1);
    apply_setting(0, 0, 0, 0, 0, 0);
    send_sample(32767, -32768);
    send_sample(1, 0);
    apply_setting(65535, 65535, 65535, 65535, 63, 63);
    send_sample(32767, 32767);
    send_sample(-32768, -32768);
    send_sample(32767, 100);

    for (int i = 0; i < 8; i++) begin
      case (i % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 61; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 61; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      case (i)
        0: apply_setting(stcd_pkg::RADIAL_RST, stcd_pkg::AXIAL_RST, stcd_pkg::OUTER_RST,
                         stcd_pkg::SLOPE_RST, stcd_pkg::SENS_RST, stcd_pkg::ACCEL_RST);
        1: apply_setting(0, 0, 0, 65535, 50, 50);
        2: apply_setting(0, 0, 0, 0, 1, 1);
        3: apply_setting(65535, 0, 0, 32768, 50, 1);
        default: apply_setting($urandom_range(0, 13000), $urandom_range(0, 8000),
                               $urandom_range(0, 8000), $urandom_range(0, 65535),
                               $urandom_range(1, 50), $urandom_range(1, 50));
      endcase
      if (i == 0) hold_cycles = 2000;
      run_random(45);
      if (i == 4) wait_drain();
      run_random(45);
    end

    wait_drain();
    repeat (300) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_stick_to_cursor_delta: done, clean");
    end else begin
      $display("tb_stick_to_cursor_delta: done, errors");
    end
    $finish;
  end

  initial begin
    #80ms;
    $display("%0t: timeout", $time);
    $display("tb_stick_to_cursor_delta: done, errors");
    $finish;
  end

endmodule
